// File: rtl/assert_macros.svh
// Assertion macros shared by the debouncer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst
`define BDRE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst
`define BDRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bdre_pkg.sv
// Types, constants and codes for the button debouncer with event FIFO
package bdre_pkg;

  localparam int NUM_BUTTONS       = 5;
  localparam int BTN_W             = $clog2(NUM_BUTTONS);
  localparam int QUEUE_DEPTH_DEF   = 16;

  localparam int ACTION_W          = 2;
  localparam int PINS_W            = 5;
  localparam int EVT_BTN_W         = 3;
  localparam int KIND_W            = 2;
  localparam int DEB_W             = 8;
  localparam int HOLD_W            = 12;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 12;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = DEB_W'(15);
  localparam logic [HOLD_W-1:0] HOLD_RST     = HOLD_W'(300);
  localparam logic [HOLD_W-1:0] REPEAT_RST   = HOLD_W'(100);
  localparam logic [DEB_W-1:0]  STEADY_MAX   = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_HOLD     = 2'd1,
    REG_REPEAT   = 2'd2
  } reg_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_HELD     = 2'd2
  } kind_t;

  typedef struct packed {
    logic [EVT_BTN_W-1:0] button;
    logic [KIND_W-1:0]    kind;
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_HOLD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic ready;     // take an input word
    logic eval;      // debounce and edge step for the current button
    logic hold;      // auto-repeat step for the current button
    logic btn_next;  // advance to the next button
    logic load_out;  // finish the item into the output register
  } cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_tick;
    logic btn_last;
    logic out_free;
  } status_t;

endpackage

// File: rtl/bdre_ifs.sv
// Handshake interfaces for the input and result channels
interface bdre_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [4:0] pin_levels;

  modport source (output valid, action, pin_levels, input ready);
  modport sink (input valid, action, pin_levels, output ready);
endinterface

interface bdre_out_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic [2:0] event_button;
  logic [1:0] event_kind;
  logic [4:0] pressed_mask;

  modport source (output valid, event_valid, event_button, event_kind, pressed_mask,
                  input ready);
  modport sink (input valid, event_valid, event_button, event_kind, pressed_mask,
                output ready);
endinterface

// File: rtl/bdre_ctrl.sv
// Sequencer: walks the buttons on a tick and finishes each item
module bdre_ctrl
  import bdre_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (status.in_fire) begin
          state_next = status.in_tick ? ST_EVAL : ST_RESULT;
        end
      end
      ST_EVAL: state_next = ST_HOLD;
      ST_HOLD: begin
        state_next = status.btn_last ? ST_RESULT : ST_EVAL;
      end
      ST_RESULT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE:   cmd.ready = 1'b1;
      ST_EVAL:   cmd.eval = 1'b1;
      ST_HOLD: begin
        cmd.hold     = 1'b1;
        cmd.btn_next = !status.btn_last;
      end
      ST_RESULT: cmd.load_out = status.out_free;
      default:   cmd = '0;
    endcase
  end

  `include "assert_macros.svh"

  `BDRE_ASSERT_NEXT(a_eval_then_hold, state == ST_EVAL, state == ST_HOLD, "eval not followed by hold")
  `BDRE_ASSERT_NEXT(a_fire_leaves_idle, status.in_fire, state != ST_IDLE, "accepted word left idle")
  `BDRE_ASSERT_NEXT(a_last_to_result, state == ST_HOLD && status.btn_last, state == ST_RESULT, "last button not followed by result")

endmodule

// File: rtl/bdre_datapath.sv
// Button state, event FIFO, config registers and result register
module bdre_datapath
  import bdre_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bdre_in_if.sink               items,
  bdre_out_if.source            results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  cmd_t                  cmd,
  output status_t               status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [DEB_W-1:0]  deb_ticks;
  logic [HOLD_W-1:0] hold_ticks;
  logic [HOLD_W-1:0] rep_ticks;

  logic [ACTION_W-1:0] act_q;
  logic [PINS_W-1:0]   pins_q;
  logic [BTN_W-1:0]    btn;

  logic [NUM_BUTTONS-1:0] raw;
  logic [NUM_BUTTONS-1:0] stable;
  logic [DEB_W-1:0]       steady [NUM_BUTTONS];
  logic [HOLD_W-1:0]      hold_left [NUM_BUTTONS];
  logic                   settled;

  event_t            mem [QUEUE_DEPTH];
  event_t            rd_data;
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W-1:0]  wr_ptr_inc;
  logic [PTR_W-1:0]  rd_ptr_inc;
  logic              full;
  logic              empty;
  logic              push_en;
  event_t            push_evt;
  logic              pop_ok;

  logic              reading;
  logic [DEB_W-1:0]  steady_next;
  logic [HOLD_W-1:0] hold_dec;
  logic              settle;
  logic              rise;
  logic              fall;
  logic              held;

  logic              out_valid;
  logic              ev_valid;
  logic [EVT_BTN_W-1:0] ev_button;
  logic [KIND_W-1:0] ev_kind;
  logic [NUM_BUTTONS-1:0] mask;

  // Handshake and status
  assign items.ready     = cmd.ready && !rst;
  assign status.in_fire  = items.valid && cmd.ready && !rst;
  assign status.in_tick  = items.action == ACT_TICK;
  assign status.btn_last = btn == BTN_W'(NUM_BUTTONS - 1);
  assign status.out_free = !out_valid || results.ready;

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      deb_ticks  <= DEBOUNCE_RST;
      hold_ticks <= HOLD_RST;
      rep_ticks  <= REPEAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE: deb_ticks  <= cfg_data[DEB_W-1:0];
        REG_HOLD:     hold_ticks <= cfg_data[HOLD_W-1:0];
        REG_REPEAT:   rep_ticks  <= cfg_data[HOLD_W-1:0];
        default:      ;
      endcase
    end
  end

  // Input word and button index
  always_ff @(posedge clk) begin
    if (status.in_fire) begin
      act_q  <= items.action;
      pins_q <= items.pin_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || status.in_fire) begin
      btn <= '0;
    end else if (cmd.btn_next) begin
      btn <= btn + 1'b1;
    end
  end

  // Per-button step
  always_comb begin
    reading = !pins_q[btn];
    if (reading != raw[btn]) begin
      steady_next = '0;
    end else if (steady[btn] != STEADY_MAX) begin
      steady_next = steady[btn] + 1'b1;
    end else begin
      steady_next = steady[btn];
    end
    hold_dec = (hold_left[btn] != '0) ? hold_left[btn] - 1'b1 : hold_left[btn];
    settle   = steady_next >= deb_ticks;
    rise     = settle && reading && !stable[btn];
    fall     = settle && !reading && stable[btn];
    held     = settled && stable[btn] && (hold_left[btn] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw     <= '0;
      stable  <= '0;
      settled <= 1'b0;
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        steady[i]    <= STEADY_MAX;
        hold_left[i] <= '0;
      end
    end else if (cmd.eval) begin
      raw[btn]    <= reading;
      steady[btn] <= steady_next;
      settled     <= settle;
      if (settle) begin
        stable[btn] <= reading;
      end
      hold_left[btn] <= rise ? hold_ticks : hold_dec;
    end else if (cmd.hold && held) begin
      hold_left[btn] <= rep_ticks;
    end
  end

  // Event FIFO
  always_comb begin
    push_evt.button = EVT_BTN_W'(btn);
    push_en         = 1'b0;
    push_evt.kind   = KIND_HELD;
    if (cmd.eval && (rise || fall)) begin
      push_en       = 1'b1;
      push_evt.kind = rise ? KIND_PRESSED : KIND_RELEASED;
    end else if (cmd.hold && held) begin
      push_en = 1'b1;
    end
  end

  assign wr_ptr_inc = (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
  assign rd_ptr_inc = (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
  assign full       = wr_ptr_inc == rd_ptr;
  assign empty      = wr_ptr == rd_ptr;
  assign pop_ok     = (act_q == ACT_POP) && !empty;

  always_ff @(posedge clk) begin
    if (push_en && !full) begin
      mem[wr_ptr] <= push_evt;
    end
    rd_data <= mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.load_out && act_q == ACT_CLEAR) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push_en && !full) begin
        wr_ptr <= wr_ptr_inc;
      end
      if (cmd.load_out && pop_ok) begin
        rd_ptr <= rd_ptr_inc;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      ev_valid  <= pop_ok;
      ev_button <= pop_ok ? rd_data.button : '0;
      ev_kind   <= pop_ok ? rd_data.kind : '0;
      mask      <= stable;
    end
  end

  assign results.valid        = out_valid;
  assign results.event_valid  = ev_valid;
  assign results.event_button = ev_button;
  assign results.event_kind   = ev_kind;
  assign results.pressed_mask = PINS_W'(mask);

  `include "assert_macros.svh"

  `BDRE_ASSERT_NEXT(a_full_drops, push_en && full, $stable(wr_ptr), "push into full FIFO moved pointer")
  `BDRE_ASSERT_NEXT(a_push_not_empty, push_en && !full, wr_ptr != rd_ptr, "FIFO empty after push")
  `BDRE_ASSERT_NOW(a_no_push_on_result, cmd.load_out, !push_en, "push during result load")

endmodule

// File: rtl/button_debounce_repeat_events_unit.sv
// Top level: five-button debouncer with auto-repeat and event FIFO
//
//  channel   dir  handshake          payload
//  items     in   valid/ready        action[1:0], pin_levels[4:0]
//  results   out  valid/ready        event_valid, event_button[2:0],
//                                    event_kind[1:0], pressed_mask[4:0]
//  cfg       in   cfg_we (no wait)   cfg_index[1:0], cfg_data[11:0]
//
// A tick runs two sequencer steps per button (eval, then hold), with
// one FIFO write port shared by the edge and the repeat event.
// Pop, clear and unused actions go from accept straight to the result load.
// Reset is synchronous; no clearing pass, the FIFO store is never read unwritten.
// A word is taken again as soon as the result is in the output register;
// a stalled result holds the block in its final step.
module button_debounce_repeat_events_unit
  import bdre_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  bdre_in_if.sink               items,
  bdre_out_if.source            results,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  bdre_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  bdre_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

// File: sim/button_debounce_repeat_events_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the five-button debouncer with auto-repeat event FIFO
module button_debounce_repeat_events_unit_tb;
  import bdre_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 105;
  localparam int NUM_PHASES = 11;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic                 valid;
    logic [EVT_BTN_W-1:0] button;
    logic [KIND_W-1:0]    kind;
    logic [PINS_W-1:0]    mask;
  } panel_word_t;

  typedef enum logic [1:0] {
    ROW_WORD,
    ROW_TYPED,
    ROW_SETTINGS
  } row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [ACTION_W-1:0] act;
    logic [PINS_W-1:0]   pins;
    panel_word_t         want;
    logic [DEB_W-1:0]    deb;
    logic [HOLD_W-1:0]   hold;
    logic [HOLD_W-1:0]   rep;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bdre_in_if  word_in ();
  bdre_out_if word_out ();

  button_debounce_repeat_events_unit dut (
    .clk       (clk),
    .rst       (rst),
    .items     (word_in),
    .results   (word_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // debouncer predictor state
  logic [DEB_W-1:0]    deb_cfg;
  logic [HOLD_W-1:0]   hold_cfg;
  logic [HOLD_W-1:0]   rep_cfg;
  logic [NUM_BUTTONS-1:0] raw_lvl;
  logic [NUM_BUTTONS-1:0] stable_lvl;
  logic [DEB_W-1:0]    steady_cnt [NUM_BUTTONS];
  logic [HOLD_W-1:0]   hold_cnt [NUM_BUTTONS];
  event_t              ev_ring [QUEUE_DEPTH_DEF];
  int                  wr_ptr;
  int                  rd_ptr;

  panel_word_t expect_q[$];
  stim_row_t   plan[$];
  logic        typed_on;
  panel_word_t typed_word;
  logic        sender_no_gap;
  int          words_sent;
  int          words_checked;
  int          fault_count;

  function automatic void queue_event(int btn, kind_t k);
    int nxt;
    nxt = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
    if (nxt != rd_ptr) begin
      ev_ring[wr_ptr].button = EVT_BTN_W'(btn);
      ev_ring[wr_ptr].kind = k;
      wr_ptr = nxt;
    end
  endfunction

  function automatic panel_word_t apply_word(logic [ACTION_W-1:0] act, logic [PINS_W-1:0] pins);
    panel_word_t w;
    logic reading;
    logic was;
    w = '0;
    case (act)
      ACT_TICK: begin
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          reading = ~pins[b];
          if (hold_cnt[b] != '0) hold_cnt[b] = hold_cnt[b] - 1'b1;
          if (reading != raw_lvl[b]) begin
            raw_lvl[b] = reading;
            steady_cnt[b] = '0;
          end else if (steady_cnt[b] != STEADY_MAX) begin
            steady_cnt[b] = steady_cnt[b] + 1'b1;
          end
          if (steady_cnt[b] >= deb_cfg) begin
            was = stable_lvl[b];
            stable_lvl[b] = raw_lvl[b];
            if (stable_lvl[b] && !was) begin
              queue_event(b, KIND_PRESSED);
              hold_cnt[b] = hold_cfg;
            end else if (!stable_lvl[b] && was) begin
              queue_event(b, KIND_RELEASED);
            end
            if (stable_lvl[b] && hold_cnt[b] == '0) begin
              queue_event(b, KIND_HELD);
              hold_cnt[b] = rep_cfg;
            end
          end
        end
      end
      ACT_POP: begin
        if (rd_ptr != wr_ptr) begin
          w.valid = 1'b1;
          w.button = ev_ring[rd_ptr].button;
          w.kind = ev_ring[rd_ptr].kind;
          rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
        end
      end
      ACT_CLEAR: begin
        wr_ptr = 0;
        rd_ptr = 0;
      end
      default: ;
    endcase
    w.mask = stable_lvl;
    return w;
  endfunction

  function automatic stim_row_t word_row(logic [ACTION_W-1:0] act, logic [PINS_W-1:0] pins);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.act = act;
    r.pins = pins;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [ACTION_W-1:0] act, logic [PINS_W-1:0] pins,
                                          logic v, logic [EVT_BTN_W-1:0] btn, kind_t k,
                                          logic [PINS_W-1:0] mask);
    stim_row_t r;
    r = word_row(act, pins);
    r.kind = ROW_TYPED;
    r.want = '{valid: v, button: btn, kind: k, mask: mask};
    return r;
  endfunction

  function automatic stim_row_t settings_row(logic [DEB_W-1:0] deb, logic [HOLD_W-1:0] hold,
                                             logic [HOLD_W-1:0] rep);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SETTINGS;
    r.deb = deb;
    r.hold = hold;
    r.rep = rep;
    return r;
  endfunction

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [PINS_W-1:0] pins,
                           input logic typed, input panel_word_t want);
    int gap;
    gap = sender_no_gap ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      word_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    word_in.valid <= 1'b1;
    word_in.action <= act;
    word_in.pin_levels <= pins;
    typed_on <= typed;
    typed_word <= want;
    do @(posedge clk); while (!word_in.ready);
    words_sent++;
  endtask

  task automatic drain();
    word_in.valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk);
  endtask

  task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] hold,
                            input logic [HOLD_W-1:0] rep);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= CFG_DATA_W'(deb);
    @(posedge clk);
    cfg_index <= REG_HOLD;
    cfg_data <= hold;
    @(posedge clk);
    cfg_index <= REG_REPEAT;
    cfg_data <= rep;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // predictor update and result check
  always @(posedge clk) begin
    panel_word_t got;
    panel_word_t want;
    if (rst) begin
      deb_cfg = DEBOUNCE_RST;
      hold_cfg = HOLD_RST;
      rep_cfg = REPEAT_RST;
      raw_lvl = '0;
      stable_lvl = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        steady_cnt[b] = STEADY_MAX;
        hold_cnt[b] = '0;
      end
      wr_ptr = 0;
      rd_ptr = 0;
      expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE: deb_cfg = cfg_data[DEB_W-1:0];
          REG_HOLD:     hold_cfg = cfg_data;
          REG_REPEAT:   rep_cfg = cfg_data;
          default: ;
        endcase
      end
      if (word_out.valid && word_out.ready) begin
        got = '{valid: word_out.event_valid, button: word_out.event_button,
                kind: word_out.event_kind, mask: word_out.pressed_mask};
        if (expect_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fault_count++;
        end else begin
          want = expect_q.pop_front();
          if (got.valid !== want.valid) begin
            $error("event_valid: expected %0d, got %0d", want.valid, got.valid);
            fault_count++;
          end
          if (got.button !== want.button) begin
            $error("event_button: expected %0d, got %0d", want.button, got.button);
            fault_count++;
          end
          if (got.kind !== want.kind) begin
            $error("event_kind: expected %0d, got %0d", want.kind, got.kind);
            fault_count++;
          end
          if (got.mask !== want.mask) begin
            $error("pressed_mask: expected 'h%02h, got 'h%02h", want.mask, got.mask);
            fault_count++;
          end
        end
        words_checked++;
      end
      if (word_in.valid && word_in.ready) begin
        want = apply_word(word_in.action, word_in.pin_levels);
        expect_q.push_back(typed_on ? typed_word : want);
      end
    end
  end

  // result side: random stalls, one long hold-off, and no-stall stretches
  initial begin
    int taken;
    int gap;
    taken = 0;
    word_out.ready = 1'b0;
    wait (!rst);
    word_out.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (word_out.valid && word_out.ready) begin
        taken++;
        if (taken == 120) gap = 400;
        else if ((taken / 160) % 3 == 1) gap = 0;
        else gap = $urandom_range(0, 4);
        if (gap > 0) begin
          word_out.ready <= 1'b0;
          repeat (gap) @(posedge clk);
          word_out.ready <= 1'b1;
        end
      end
    end
  end

  initial begin
    stim_row_t r;
    logic [ACTION_W-1:0] act;
    logic [PINS_W-1:0] pins;
    logic [PINS_W-1:0] cur_pins;
    int roll;

    word_in.valid = 1'b0;
    word_in.action = ACT_TICK;
    word_in.pin_levels = '1;
    cfg_we = 1'b0;
    cfg_index = REG_DEBOUNCE;
    cfg_data = '0;
    typed_on = 1'b0;
    typed_word = '0;
    sender_no_gap = 1'b0;
    words_sent = 0;
    words_checked = 0;
    fault_count = 0;
    cur_pins = '1;

    // reset values first, then extremes of the settings and the FIFO
    plan.push_back(typed_row(ACT_POP,   5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(typed_row(ACT_SPARE, 5'h1F, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(typed_row(ACT_CLEAR, 5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(typed_row(ACT_TICK,  5'h1F, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(typed_row(ACT_TICK,  5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(settings_row(8'd0, 12'd0, 12'd0));
    plan.push_back(typed_row(ACT_TICK,  5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h1F));
    plan.push_back(typed_row(ACT_POP,   5'h00, 1'b1, 3'd0, KIND_PRESSED, 5'h1F));
    plan.push_back(typed_row(ACT_POP,   5'h00, 1'b1, 3'd0, KIND_HELD, 5'h1F));
    plan.push_back(word_row(ACT_TICK, 5'h00));
    plan.push_back(typed_row(ACT_TICK,  5'h1F, 1'b0, 3'd0, KIND_PRESSED, 5'h00));
    plan.push_back(typed_row(ACT_TICK,  5'h15, 1'b0, 3'd0, KIND_PRESSED, 5'h0A));
    plan.push_back(word_row(ACT_POP, 5'h00));
    plan.push_back(word_row(ACT_POP, 5'h1F));
    plan.push_back(word_row(ACT_POP, 5'h00));
    plan.push_back(typed_row(ACT_CLEAR, 5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h0A));
    plan.push_back(typed_row(ACT_POP,   5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h0A));
    plan.push_back(settings_row(8'd255, 12'd4095, 12'd4095));
    plan.push_back(typed_row(ACT_TICK,  5'h0A, 1'b0, 3'd0, KIND_PRESSED, 5'h0A));
    plan.push_back(typed_row(ACT_POP,   5'h00, 1'b0, 3'd0, KIND_PRESSED, 5'h0A));
    plan.push_back(settings_row(8'd2, 12'd3, 12'd1));
    plan.push_back(word_row(ACT_TICK, 5'h0A));
    plan.push_back(word_row(ACT_TICK, 5'h0A));
    plan.push_back(word_row(ACT_TICK, 5'h0A));
    plan.push_back(word_row(ACT_POP, 5'h00));
    plan.push_back(word_row(ACT_POP, 5'h00));

    wait (!rst);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_SETTINGS) write_regs(r.deb, r.hold, r.rep);
      else send_word(r.act, r.pins, r.kind == ROW_TYPED, r.want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: write_regs(8'd1, 12'd4, 12'd2);
        1: write_regs(8'd0, 12'd0, 12'd0);
        2: write_regs(8'd3, 12'd10, 12'd3);
        3: write_regs(8'd0, 12'd4095, 12'd0);
        4: write_regs(8'd2, 12'd0, 12'd5);
        5: write_regs(8'd255, 12'd4095, 12'd4095);
        6: write_regs(DEB_W'($urandom_range(0, 255)), HOLD_W'($urandom_range(0, 4095)),
                      HOLD_W'($urandom_range(0, 4095)));
        7: write_regs(8'd4, 12'd15, 12'd4);
        8: write_regs(8'd1, 12'd2, 12'd1);
        9: write_regs(DEB_W'($urandom_range(0, 6)), HOLD_W'($urandom_range(0, 30)),
                      HOLD_W'($urandom_range(0, 12)));
        default: write_regs(8'd2, 12'd6, 12'd2);
      endcase
      sender_no_gap = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          // mostly steady pins, occasional bounce on a random subset
          if ($urandom_range(0, 99) < 12) cur_pins = cur_pins ^ PINS_W'($urandom_range(1, 31));
          act = ACT_TICK;
        end else if (roll < 92) begin
          act = ACT_POP;
        end else if (roll < 96) begin
          act = ACT_CLEAR;
        end else begin
          act = ACT_SPARE;
        end
        pins = (act == ACT_TICK) ? cur_pins : PINS_W'($urandom());
        send_word(act, pins, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expect_q.size() != 0) begin
      $error("%0d expected result words never arrived", expect_q.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
